@@ rtl/msft_pkg.sv @@
// Shared types and constants for the message flow statistics table.
package msft_pkg;

    // Protocol classes carried in the request kind field.
    localparam logic [2:0] PROTO_BIN_DATA = 3'd0;
    localparam logic [2:0] PROTO_BIN_CMD  = 3'd1;
    localparam logic [2:0] PROTO_ACK      = 3'd5;
    localparam logic [2:0] PROTO_ERROR    = 3'd6;

    // Fixed entries held outside the table.
    localparam logic FIXED_ACK = 1'b0;
    localparam logic FIXED_ERR = 1'b1;

    localparam int unsigned KEY_W         = 35;
    localparam int unsigned MS_PER_SECOND = 1000;
    localparam logic [15:0] WINDOW_RESET  = 16'd1000;

    // The scaled window bytes fit in 42 bits since 1000 is below 1024.
    localparam int unsigned PROD_W    = 42;
    localparam int unsigned DIV_STEPS = PROD_W;
    localparam int unsigned DCNT_W    = 6;

    typedef struct packed {
        logic [31:0] rate;
        logic [31:0] window_bytes;
        logic [31:0] window_start;
        logic [31:0] last_time;
        logic [31:0] prev_time;
        logic [31:0] count;
    } stats_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIXED,
        S_SCAN,
        S_LOAD,
        S_UPD,
        S_MUL,
        S_DIV,
        S_FIN,
        S_WB,
        S_DONE
    } state_t;

endpackage

@@ rtl/message_flow_statistics_table.sv @@
// Per-flow message statistics table with a serial rate divider.
//
//  Channel  Direction  Handshake          Payload
//  s_*      in         s_tvalid/s_tready  tdata id,bytes,time; tuser protocol
//  m_*      out        m_tvalid/m_tready  tdata count,interval,rate; tuser flags
//  cfg_*    in         cfg_we             cfg_wdata window span in ms
//
// An ack or error request skips the key scan; a table request scans up to
// every filled slot, since the key scan reads one slot per cycle from the
// key memory. A rate recompute adds a pass of the one-bit-per-cycle divider.
// Reset empties the table at once through the fill count, so no clearing
// pass is needed. The result sits in an output register; a new request is
// taken while it waits, and the block stalls only when the next result is
// ready and the previous one is still held.
module message_flow_statistics_table #(
    parameter int unsigned TABLE_ENTRIES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // message_id[31:0], byte_count[47:32], time_ms[79:48]
    input  logic [2:0]  s_tuser,   // protocol[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // message_count[31:0], interval_ms[63:32],
                                   // bytes_per_second[95:64]
    output logic [1:0]  m_tuser,   // table_full[0], new_entry[1]
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
    localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int unsigned KW    = msft_pkg::KEY_W;
    localparam int unsigned PW    = msft_pkg::PROD_W;

    // Control and working registers.
    msft_pkg::state_t  state_reg, state_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  pend_idx_reg, pend_idx_next;
    logic [IDX_W-1:0]  slot_reg, slot_next;
    logic [KW-1:0]     key_reg, key_next;
    logic [31:0]       now_reg, now_next;
    logic [15:0]       bytes_reg, bytes_next;
    logic              is_fixed_reg, is_fixed_next;
    logic              fixed_sel_reg, fixed_sel_next;
    logic              new_reg, new_next;
    logic              full_reg, full_next;
    msft_pkg::stats_t  cur_reg, cur_next;
    logic [31:0]       elapsed_reg, elapsed_next;
    logic [PW-1:0]     quo_reg, quo_next;
    logic [31:0]       rem_reg, rem_next;
    logic [msft_pkg::DCNT_W-1:0] dcnt_reg, dcnt_next;
    msft_pkg::stats_t  fixed_reg [2];
    msft_pkg::stats_t  fixed_next [2];
    logic [15:0]       window_reg;
    logic              m_valid_reg, m_valid_next;
    logic [95:0]       m_data_reg, m_data_next;
    logic [1:0]        m_user_reg, m_user_next;

    // Memory ports.
    logic [KW-1:0]     key_mem [TABLE_ENTRIES];
    msft_pkg::stats_t  stats_mem [TABLE_ENTRIES];
    logic [KW-1:0]     key_q;
    msft_pkg::stats_t  stats_q;
    logic              key_rd_en;
    logic              key_we;
    logic              stats_rd_en;
    logic              stats_we;

    // Datapath helpers.
    logic [32:0]       wb_sum;
    logic [31:0]       wb_sat;
    logic [31:0]       elapsed_now;
    logic [15:0]       span;
    logic [32:0]       div_shift;
    logic [32:0]       div_diff;
    logic              div_ge;
    logic              match;
    logic [31:0]       interval;

    assign s_tready = (state_reg == msft_pkg::S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // Saturating window byte sum and elapsed window time.
    assign wb_sum      = {1'b0, cur_reg.window_bytes} + {17'b0, bytes_reg};
    assign wb_sat      = wb_sum[32] ? 32'hFFFF_FFFF : wb_sum[31:0];
    assign elapsed_now = now_reg - cur_reg.window_start;
    assign span        = (window_reg == 16'd0) ? 16'd1 : window_reg;

    // One restoring divide step.
    assign div_shift = {rem_reg, quo_reg[PW-1]};
    assign div_diff  = div_shift - {1'b0, elapsed_reg};
    assign div_ge    = (div_shift >= {1'b0, elapsed_reg});

    assign match    = pend_reg && (key_q == key_reg);
    assign interval = (cur_reg.prev_time != 32'd0) ?
                      (cur_reg.last_time - cur_reg.prev_time) : 32'd0;

    // Key memory: one read port for the scan, one write port for new slots.
    always_ff @(posedge clk)
    begin
        if (key_rd_en)
        begin
            key_q <= key_mem[scan_reg[IDX_W-1:0]];
        end
        if (key_we)
        begin
            key_mem[fill_reg[IDX_W-1:0]] <= key_reg;
        end
    end

    // Stats memory: read for a hit, written back after the update.
    always_ff @(posedge clk)
    begin
        if (stats_rd_en)
        begin
            stats_q <= stats_mem[pend_idx_reg];
        end
        if (stats_we)
        begin
            stats_mem[slot_reg] <= cur_reg;
        end
    end

    // Next state, datapath and memory controls.
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        scan_next      = scan_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        slot_next      = slot_reg;
        key_next       = key_reg;
        now_next       = now_reg;
        bytes_next     = bytes_reg;
        is_fixed_next  = is_fixed_reg;
        fixed_sel_next = fixed_sel_reg;
        new_next       = new_reg;
        full_next      = full_reg;
        cur_next       = cur_reg;
        elapsed_next   = elapsed_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        dcnt_next      = dcnt_reg;
        fixed_next     = fixed_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        m_user_next    = m_user_reg;
        key_rd_en      = 1'b0;
        key_we         = 1'b0;
        stats_rd_en    = 1'b0;
        stats_we       = 1'b0;

        unique case (state_reg)
            msft_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    now_next      = s_tdata[79:48];
                    bytes_next    = s_tdata[47:32];
                    new_next      = 1'b0;
                    full_next     = 1'b0;
                    is_fixed_next = 1'b0;
                    scan_next     = '0;
                    pend_next     = 1'b0;
                    priority if (s_tuser == msft_pkg::PROTO_ACK)
                    begin
                        is_fixed_next  = 1'b1;
                        fixed_sel_next = msft_pkg::FIXED_ACK;
                        state_next     = msft_pkg::S_FIXED;
                    end
                    else if (s_tuser >= msft_pkg::PROTO_ERROR)
                    begin
                        is_fixed_next  = 1'b1;
                        fixed_sel_next = msft_pkg::FIXED_ERR;
                        state_next     = msft_pkg::S_FIXED;
                    end
                    else
                    begin
                        // Binary data and command share one key space.
                        key_next   = {(s_tuser == msft_pkg::PROTO_BIN_CMD) ?
                                      msft_pkg::PROTO_BIN_DATA : s_tuser,
                                      s_tdata[31:0]};
                        state_next = msft_pkg::S_SCAN;
                    end
                end
            end

            msft_pkg::S_FIXED:
            begin
                cur_next   = fixed_reg[fixed_sel_reg];
                state_next = msft_pkg::S_UPD;
            end

            msft_pkg::S_SCAN:
            begin
                // Compare the slot read last cycle while the next one is read.
                priority if (match)
                begin
                    slot_next   = pend_idx_reg;
                    stats_rd_en = 1'b1;
                    state_next  = msft_pkg::S_LOAD;
                end
                else if (!pend_reg && (scan_reg == fill_reg))
                begin
                    if (fill_reg == CNT_W'(TABLE_ENTRIES))
                    begin
                        full_next  = 1'b1;
                        state_next = msft_pkg::S_DONE;
                    end
                    else
                    begin
                        key_we                = 1'b1;
                        slot_next             = fill_reg[IDX_W-1:0];
                        fill_next             = fill_reg + CNT_W'(1);
                        new_next              = 1'b1;
                        cur_next              = '0;
                        cur_next.prev_time    = now_reg;
                        cur_next.last_time    = now_reg;
                        state_next            = msft_pkg::S_UPD;
                    end
                end
                else if (scan_reg != fill_reg)
                begin
                    key_rd_en     = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = scan_reg[IDX_W-1:0];
                    scan_next     = scan_reg + CNT_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end

            msft_pkg::S_LOAD:
            begin
                cur_next   = stats_q;
                state_next = msft_pkg::S_UPD;
            end

            msft_pkg::S_UPD:
            begin
                cur_next.count        = cur_reg.count + 32'd1;
                cur_next.prev_time    = cur_reg.last_time;
                cur_next.last_time    = now_reg;
                cur_next.window_bytes = wb_sat;
                elapsed_next          = elapsed_now;
                state_next            = msft_pkg::S_WB;
                if (cur_reg.window_start == 32'd0)
                begin
                    cur_next.window_start = now_reg;
                end
                else if (elapsed_now >= {16'b0, span})
                begin
                    state_next = msft_pkg::S_MUL;
                end
            end

            msft_pkg::S_MUL:
            begin
                quo_next   = {{(PW-32){1'b0}}, cur_reg.window_bytes} *
                             PW'(msft_pkg::MS_PER_SECOND);
                rem_next   = '0;
                dcnt_next  = '0;
                state_next = msft_pkg::S_DIV;
            end

            msft_pkg::S_DIV:
            begin
                rem_next  = div_ge ? div_diff[31:0] : div_shift[31:0];
                quo_next  = {quo_reg[PW-2:0], div_ge};
                dcnt_next = dcnt_reg + msft_pkg::DCNT_W'(1);
                if (dcnt_reg == msft_pkg::DCNT_W'(msft_pkg::DIV_STEPS - 1))
                begin
                    state_next = msft_pkg::S_FIN;
                end
            end

            msft_pkg::S_FIN:
            begin
                cur_next.rate         = (quo_reg[PW-1:32] != '0) ?
                                        32'hFFFF_FFFF : quo_reg[31:0];
                cur_next.window_bytes = '0;
                cur_next.window_start = now_reg;
                state_next            = msft_pkg::S_WB;
            end

            msft_pkg::S_WB:
            begin
                if (is_fixed_reg)
                begin
                    fixed_next[fixed_sel_reg] = cur_reg;
                end
                else
                begin
                    stats_we = 1'b1;
                end
                state_next = msft_pkg::S_DONE;
            end

            msft_pkg::S_DONE:
            begin
                // Load the output register once it is free.
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    if (full_reg)
                    begin
                        m_data_next = '0;
                        m_user_next = 2'b01;
                    end
                    else
                    begin
                        m_data_next = {cur_reg.rate, interval, cur_reg.count};
                        m_user_next = {new_reg, 1'b0};
                    end
                    state_next = msft_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = msft_pkg::S_IDLE;
            end
        endcase
    end

    // Control state and fixed entries.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= msft_pkg::S_IDLE;
            fill_reg     <= '0;
            m_valid_reg  <= 1'b0;
            window_reg   <= msft_pkg::WINDOW_RESET;
            fixed_reg[0] <= '0;
            fixed_reg[1] <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            m_valid_reg  <= m_valid_next;
            fixed_reg[0] <= fixed_next[0];
            fixed_reg[1] <= fixed_next[1];
            if (cfg_we)
            begin
                window_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        scan_reg      <= scan_next;
        pend_reg      <= pend_next;
        pend_idx_reg  <= pend_idx_next;
        slot_reg      <= slot_next;
        key_reg       <= key_next;
        now_reg       <= now_next;
        bytes_reg     <= bytes_next;
        is_fixed_reg  <= is_fixed_next;
        fixed_sel_reg <= fixed_sel_next;
        new_reg       <= new_next;
        full_reg      <= full_next;
        cur_reg       <= cur_next;
        elapsed_reg   <= elapsed_next;
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        dcnt_reg      <= dcnt_next;
        m_data_reg    <= m_data_next;
        m_user_reg    <= m_user_next;
    end

`ifndef SYNTHESIS
    // The fill count never passes the table size.
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(TABLE_ENTRIES))
    else $error("fill count beyond table size");

    // A table full result is only given once every slot is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (fill_reg == CNT_W'(TABLE_ENTRIES)))
    else $error("table full reported with free slots");

    // A result never flags both a new entry and a full table.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("new entry and table full both set");

    // An accepted request always starts work in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg != msft_pkg::S_IDLE))
    else $error("accepted request left idle");
`endif

endmodule

@@ tb/sv/message_flow_statistics_table_test.sv @@
// Self-checking testbench for the message flow statistics table.
module message_flow_statistics_table_test;

    localparam int unsigned SLOTS = 64;

    // Protocol classes that the package does not name.
    localparam logic [2:0] PROTO_NMEA  = 3'd2;
    localparam logic [2:0] PROTO_UBX   = 3'd3;
    localparam logic [2:0] PROTO_RTCM3 = 3'd4;
    localparam logic [2:0] PROTO_OTHER = 3'd7;

    localparam int unsigned CYCLE_LIMIT  = 20_000_000;
    localparam int unsigned DRAIN_CYCLES = 150;
    localparam int unsigned REPORT_LINES = 30;
    localparam int unsigned PHASE_ITEMS  = 370;

    typedef struct {
        logic [2:0]  proto;
        logic [31:0] msg_id;
        logic [15:0] nbytes;
        logic [31:0] stamp;
    } msg_req_t;

    typedef struct {
        logic        full;
        logic        created;
        logic [31:0] count;
        logic [31:0] interval;
        logic [31:0] rate;
    } flow_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;   // message_id[31:0], byte_count[47:32], time_ms[79:48]
    logic [2:0]  s_tuser;   // protocol[2:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;   // message_count[31:0], interval_ms[63:32], bytes_per_second[95:64]
    logic [1:0]  m_tuser;   // table_full[0], new_entry[1]
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    // Predicted table state.
    logic [15:0]      window_span;
    logic [34:0]      slot_key_m [SLOTS];
    msft_pkg::stats_t slot_stat [SLOTS];
    msft_pkg::stats_t fixed_stat [2];
    int unsigned      slots_filled;
    flow_result_t     pending_results [$];
    flow_result_t     head_result;

    // Run bookkeeping.
    logic [31:0]  stamp_base;
    bit           steady_mode;
    int unsigned  burst_left;
    int unsigned  sent_count;
    int unsigned  result_count;
    int unsigned  error_count;
    int unsigned  created_count;
    int unsigned  dropped_count;
    int unsigned  setting_count;
    int unsigned  cycle_count;

    message_flow_statistics_table #(
        .TABLE_ENTRIES(SLOTS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // One statistics update: count, shift the times, and fold the bytes into the rate window.
    function automatic msft_pkg::stats_t advance_flow(input msft_pkg::stats_t s,
                                                      input logic [31:0] now,
                                                      input logic [15:0] nbytes);
        logic [32:0] sum;
        logic [31:0] span;
        logic [31:0] elapsed;
        logic [63:0] quot;
        begin
            s.count = s.count + 32'd1;
            s.prev_time = s.last_time;
            s.last_time = now;
            sum = {1'b0, s.window_bytes} + {17'd0, nbytes};
            s.window_bytes = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            if (s.window_start == 32'd0)
            begin
                s.window_start = now;
            end
            else
            begin
                span = (window_span == 16'd0) ? 32'd1 : {16'd0, window_span};
                elapsed = now - s.window_start;
                if (elapsed >= span)
                begin
                    quot = ({32'd0, s.window_bytes} * msft_pkg::MS_PER_SECOND) /
                           {32'd0, elapsed};
                    s.rate = (quot[63:32] != 32'd0) ? 32'hFFFF_FFFF : quot[31:0];
                    s.window_bytes = 32'd0;
                    s.window_start = now;
                end
            end
            return s;
        end
    endfunction

    function automatic flow_result_t flow_outcome(input logic full, input logic created,
                                                  input msft_pkg::stats_t s);
        flow_result_t res;
        begin
            res.full = full;
            res.created = created;
            res.count = s.count;
            res.interval = (s.prev_time != 32'd0) ? s.last_time - s.prev_time : 32'd0;
            res.rate = s.rate;
            return res;
        end
    endfunction

    // Works out the result of one request and moves the predicted table along.
    function automatic flow_result_t predict_flow_result(input msg_req_t r);
        logic [2:0]       cls;
        logic [34:0]      key;
        int               hit;
        msft_pkg::stats_t fresh;
        begin
            if (r.proto == msft_pkg::PROTO_ACK)
            begin
                fixed_stat[msft_pkg::FIXED_ACK] =
                    advance_flow(fixed_stat[msft_pkg::FIXED_ACK], r.stamp, r.nbytes);
                return flow_outcome(1'b0, 1'b0, fixed_stat[msft_pkg::FIXED_ACK]);
            end
            if (r.proto >= msft_pkg::PROTO_ERROR)
            begin
                fixed_stat[msft_pkg::FIXED_ERR] =
                    advance_flow(fixed_stat[msft_pkg::FIXED_ERR], r.stamp, r.nbytes);
                return flow_outcome(1'b0, 1'b0, fixed_stat[msft_pkg::FIXED_ERR]);
            end

            // Binary commands share the key space of binary data.
            cls = (r.proto == msft_pkg::PROTO_BIN_CMD) ? msft_pkg::PROTO_BIN_DATA : r.proto;
            key = {cls, r.msg_id};
            hit = -1;
            for (int i = 0; i < slots_filled; i++)
            begin
                if (hit < 0 && slot_key_m[i] == key)
                    hit = i;
            end
            if (hit >= 0)
            begin
                slot_stat[hit] = advance_flow(slot_stat[hit], r.stamp, r.nbytes);
                return flow_outcome(1'b0, 1'b0, slot_stat[hit]);
            end
            if (slots_filled == SLOTS)
            begin
                dropped_count++;
                return flow_outcome(1'b1, 1'b0, '0);
            end

            // Slots are never freed, so the lowest free slot is the fill count.
            fresh = '0;
            fresh.prev_time = r.stamp;
            fresh.last_time = r.stamp;
            slot_key_m[slots_filled] = key;
            slot_stat[slots_filled] = advance_flow(fresh, r.stamp, r.nbytes);
            slots_filled++;
            created_count++;
            return flow_outcome(1'b0, 1'b1, slot_stat[slots_filled - 1]);
        end
    endfunction

    // Prints one line per mismatch, up to a cap, and counts every one.
    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        begin
            if (error_count < REPORT_LINES)
                $display("result %0d: %s expected %h, got %h", result_count, field, want, got);
            error_count++;
        end
    endtask

    // Sends one request, with a random gap at the end of each burst.
    task automatic send_message(input logic [2:0] proto, input logic [31:0] msg_id,
                                input logic [15:0] nbytes, input logic [31:0] stamp);
        msg_req_t    r;
        int unsigned gap;
        begin
            r.proto = proto;
            r.msg_id = msg_id;
            r.nbytes = nbytes;
            r.stamp = stamp;
            if (burst_left == 0 && !steady_mode)
            begin
                gap = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 120 : 8);
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
                burst_left = $urandom_range(1, 24);
            end
            @(negedge clk);
            s_tvalid <= 1'b1;
            s_tdata <= {r.stamp, r.nbytes, r.msg_id};
            s_tuser <= r.proto;
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            pending_results.insert(pending_results.size(), predict_flow_result(r));
            sent_count++;
            if (burst_left > 0)
                burst_left--;
        end
    endtask

    // Holds the sender off until every predicted result has come back.
    task automatic wait_drain();
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            while (pending_results.size() != 0)
                @(negedge clk);
            repeat (8) @(negedge clk);
        end
    endtask

    task automatic write_window(input logic [15:0] span);
        begin
            wait_drain();
            @(negedge clk);
            cfg_we <= 1'b1;
            cfg_wdata <= span;
            @(negedge clk);
            cfg_we <= 1'b0;
            window_span = span;
            setting_count++;
        end
    endtask

    // Every class, the field extremes, unstarted windows and wrapping timestamps.
    task automatic test_directed();
        begin
            // A zero time leaves the ack window unstarted and the interval at zero.
            send_message(msft_pkg::PROTO_ACK, 32'hFFFF_FFFF, 16'd0, 32'd0);
            send_message(msft_pkg::PROTO_ACK, 32'd0, 16'hFFFF, 32'd100);
            send_message(msft_pkg::PROTO_ACK, 32'd7, 16'd10, 32'd1100);
            // Parse errors and the other class land in the same entry.
            send_message(msft_pkg::PROTO_ERROR, 32'd0, 16'd1, 32'd5);
            send_message(PROTO_OTHER, 32'hFFFF_FFFF, 16'd1, 32'd6);
            // Binary data and binary command share a key.
            send_message(msft_pkg::PROTO_BIN_DATA, 32'd0, 16'd20, 32'd1);
            send_message(msft_pkg::PROTO_BIN_CMD, 32'd0, 16'd30, 32'd2);
            send_message(PROTO_NMEA, 32'd0, 16'd40, 32'd3);
            send_message(PROTO_UBX, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
            send_message(PROTO_RTCM3, 32'h8000_0000, 16'd1, 32'h8000_0000);
            // A new key created at time zero, then hits inside and past the span.
            send_message(PROTO_NMEA, 32'd1, 16'd5, 32'd0);
            send_message(PROTO_NMEA, 32'd1, 16'd5, 32'd500);
            send_message(PROTO_NMEA, 32'd1, 16'd5, 32'd1500);
            send_message(PROTO_NMEA, 32'd0, 16'd50, 32'd0);
            // Elapsed time taken across the timestamp wrap.
            send_message(PROTO_UBX, 32'hFFFF_FFFF, 16'hFFFF, 32'd999);
            send_message(msft_pkg::PROTO_ACK, 32'd0, 16'd1, 32'hFFFF_FFFF);
            send_message(msft_pkg::PROTO_ACK, 32'd0, 16'd1, 32'd998);
        end
    endtask

    // Mostly hits on known keys with random content, plus new keys and fixed-entry traffic.
    task automatic test_random_phase(input logic [15:0] span, input int unsigned count);
        msg_req_t    r;
        int unsigned pick;
        int unsigned slot;
        int unsigned roll;
        begin
            write_window(span);
            stamp_base = ($urandom_range(0, 1) == 1) ? 32'hFFFF_F000 : $urandom;
            repeat (count)
            begin
                pick = $urandom_range(0, 99);
                r.msg_id = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom;
                if (pick < 70 && slots_filled > 0)
                begin
                    slot = $urandom_range(0, slots_filled - 1);
                    r.proto = slot_key_m[slot][34:32];
                    r.msg_id = slot_key_m[slot][31:0];
                    if (r.proto == msft_pkg::PROTO_BIN_DATA && $urandom_range(0, 1) == 1)
                        r.proto = msft_pkg::PROTO_BIN_CMD;
                end
                else if (pick < 82)
                    r.proto = 3'($urandom_range(msft_pkg::PROTO_BIN_DATA, PROTO_RTCM3));
                else if (pick < 91)
                    r.proto = msft_pkg::PROTO_ACK;
                else if (pick < 96)
                    r.proto = msft_pkg::PROTO_ERROR;
                else
                    r.proto = PROTO_OTHER;

                roll = $urandom_range(0, 9);
                if (roll == 0)
                    r.nbytes = 16'd0;
                else if (roll == 1)
                    r.nbytes = 16'hFFFF;
                else if (roll < 6)
                    r.nbytes = 16'($urandom_range(0, 1500));
                else
                    r.nbytes = 16'($urandom);

                // Time creeps forward or steps on, often past the span, and rarely jumps or is zero.
                roll = $urandom_range(0, 19);
                if (roll < 8)
                    stamp_base = stamp_base + $urandom_range(0, 3);
                else if (roll < 17)
                    stamp_base = stamp_base + $urandom_range(0, 2 * window_span + 2);
                else if (roll < 18)
                    stamp_base = $urandom;
                r.stamp = (roll == 19) ? 32'd0 : stamp_base;

                send_message(r.proto, r.msg_id, r.nbytes, r.stamp);
            end
        end
    endtask

    // Fills every free slot, then offers new keys that must be dropped.
    task automatic test_table_full();
        begin
            while (slots_filled < SLOTS)
                send_message(PROTO_RTCM3, $urandom, 16'($urandom), $urandom);
            repeat (4) send_message(PROTO_NMEA, $urandom, 16'($urandom), $urandom);
        end
    endtask

    // Piles bytes into a window that has not elapsed, then closes it after one ms.
    task automatic test_rate_saturation();
        begin
            write_window(16'd1);
            steady_mode = 1'b1;
            repeat (70) send_message(msft_pkg::PROTO_ERROR, $urandom, 16'hFFFF, 32'h0001_0000);
            send_message(msft_pkg::PROTO_ERROR, 32'd0, 16'hFFFF, 32'h0001_0001);
            steady_mode = 1'b0;
        end
    endtask

    // Receiver stalls follow a rotating pattern that is reloaded now and then.
    initial
    begin : rx_stall
        logic [15:0] pattern;
        int unsigned hold;
        m_tready = 1'b0;
        pattern = 16'hFFFF;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (hold == 0)
            begin
                hold = $urandom_range(16, 160);
                case ($urandom_range(0, 3))
                    0: pattern = 16'hFFFF;
                    1: pattern = 16'($urandom | $urandom);
                    default: pattern = 16'($urandom);
                endcase
            end
            hold--;
            pattern = {pattern[14:0], pattern[15]};
            m_tready <= steady_mode ? 1'b1 : pattern[0];
        end
    end

    // Compares each accepted result with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            result_count++;
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result, message_count", 32'd0, m_tdata[31:0]);
            end
            else
            begin
                head_result = pending_results.pop_front();
                if (m_tuser[0] !== head_result.full)
                    report_mismatch("table_full", {31'd0, head_result.full}, {31'd0, m_tuser[0]});
                if (m_tuser[1] !== head_result.created)
                    report_mismatch("new_entry", {31'd0, head_result.created},
                                    {31'd0, m_tuser[1]});
                if (m_tdata[31:0] !== head_result.count)
                    report_mismatch("message_count", head_result.count, m_tdata[31:0]);
                if (m_tdata[63:32] !== head_result.interval)
                    report_mismatch("interval_ms", head_result.interval, m_tdata[63:32]);
                if (m_tdata[95:64] !== head_result.rate)
                    report_mismatch("bytes_per_second", head_result.rate, m_tdata[95:64]);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Reset, then the tests in turn, then the final verdict.
    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        steady_mode = 1'b0;
        burst_left = 0;
        sent_count = 0;
        created_count = 0;
        dropped_count = 0;
        setting_count = 0;
        stamp_base = '0;
        window_span = msft_pkg::WINDOW_RESET;
        slots_filled = 0;
        fixed_stat[msft_pkg::FIXED_ACK] = '0;
        fixed_stat[msft_pkg::FIXED_ERR] = '0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_phase(16'd1000, PHASE_ITEMS);
        test_random_phase(16'd1, PHASE_ITEMS);
        test_table_full();
        test_random_phase(16'd0, PHASE_ITEMS);
        test_random_phase(16'hFFFF, PHASE_ITEMS);
        test_random_phase(16'($urandom_range(2, 65534)), PHASE_ITEMS);
        test_rate_saturation();

        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d requests and %0d results over %0d window settings.",
                 sent_count, result_count, setting_count);
        $display("Table entries created: %0d; new keys dropped on a full table: %0d.",
                 created_count, dropped_count);
        if (error_count == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
